FILE: sv/mf_pkg.sv
`default_nettype none

package mf_pkg;

  // Pixel and configuration widths
  localparam int PIX_W      = 8;
  localparam int COLS_W     = 12;
  localparam int ROWS_W     = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Default geometry limits and register reset values
  localparam int MAX_COLS_DEF = 2048;
  localparam int MAX_ROWS_DEF = 4096;
  localparam logic [COLS_W-1:0] COLS_RESET = 12'd640;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd480;

  // Window and output queue sizes
  localparam int WIN_N      = 3;
  localparam int FIFO_DEPTH = 8;

  // Line store entry: upper line byte over middle line byte
  localparam int LINE_W = 2 * PIX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COLS = 1'b0,
    CFG_FRAME_ROWS = 1'b1
  } mf_cfg_idx_t;

  // One window column, held in sorted order
  typedef struct packed {
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] lo;
  } mf_col_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             end_of_line;
    logic             end_of_frame;
  } mf_out_t;

  // Sort three values into a column.
  function automatic mf_col_t sort3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                    input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    mf_col_t          r;
    x = (a < b) ? a : b;
    y = (a < b) ? b : a;
    if (c < x) begin
      r.lo = c; r.mid = x; r.hi = y;
    end else if (c < y) begin
      r.lo = x; r.mid = c; r.hi = y;
    end else begin
      r.lo = x; r.mid = y; r.hi = c;
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] t;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    t  = (hi < c) ? hi : c;
    return (lo > t) ? lo : t;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mf_in_if.sv
`default_nettype none

// Input pixel stream
interface mf_in_if;
  logic                     valid;
  logic                     ready;
  logic [mf_pkg::PIX_W-1:0] pixel;
  logic                     drain;

  modport source (output valid, output pixel, output drain, input ready);
  modport sink   (input valid, input pixel, input drain, output ready);
endinterface

`default_nettype wire

FILE: sv/mf_out_if.sv
`default_nettype none

// Filtered result stream
interface mf_out_if;
  logic                     valid;
  logic                     ready;
  logic [mf_pkg::PIX_W-1:0] filtered;
  logic                     end_of_line;
  logic                     end_of_frame;

  modport source (output valid, output filtered, output end_of_line, output end_of_frame,
                  input ready);
  modport sink   (input valid, input filtered, input end_of_line, input end_of_frame,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/mf_ram.sv
`default_nettype none

module mf_ram #(
  parameter int WIDTH = mf_pkg::LINE_W,
  parameter int DEPTH = mf_pkg::MAX_COLS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write and one registered read per cycle; a read at the written
  // address returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/mf_col_cell.sv
`default_nettype none

module mf_col_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire mf_pkg::mf_col_t col_in,
  output mf_pkg::mf_col_t      col_q
);
  import mf_pkg::*;

  mf_col_t col_r;

  // Hold one sorted window column; take the neighbour's column on each pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_q = col_r;

endmodule

`default_nettype wire

FILE: sv/median_filter_3x3.sv
`default_nettype none

// Channel   Role     Fields
// in_ch     sink     pixel[7:0], drain
// out_ch    source   filtered[7:0], end_of_line, end_of_frame
// cfg_*     write    index 0: frame_cols[11:0], index 1: frame_rows[12:0]
//
// One item is taken per clock while in_ch.ready is high. On its way to the
// output queue a result passes the line store read, the column sort and the
// partial medians, each registered, and then its final median is written into
// the queue. Reset clears the counters, the window columns and the output queue;
// the line stores are not cleared. in_ch.ready falls only when eight results are
// owed, so a stall on out_ch reaches the input once the output queue could fill.
module median_filter_3x3 #(
  parameter int MAX_COLS = mf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mf_pkg::MAX_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mf_in_if.sink                              in_ch,
  mf_out_if.source                           out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [mf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mf_pkg::*;

  localparam int CB   = $clog2(MAX_COLS);
  localparam int CNTW = $clog2(MAX_COLS + 1);
  localparam int RB   = $clog2(MAX_ROWS);
  localparam int RNTW = $clog2(MAX_ROWS + 1);
  localparam int LW   = $clog2(MAX_COLS + 2);
  localparam int CEW  = (CNTW > COLS_W) ? CNTW : COLS_W;
  localparam int REW  = (RNTW > ROWS_W) ? RNTW : ROWS_W;
  localparam int FPW  = $clog2(FIFO_DEPTH);
  localparam int FCW  = FPW + 1;

  typedef struct packed {
    logic             vld;
    logic             pix;
    logic             emit;
    logic             inter;
    logic             eol;
    logic             eof;
    logic [CB-1:0]    addr;
    logic [PIX_W-1:0] px;
  } s1_t;

  typedef struct packed {
    logic emit;
    logic inter;
    logic eol;
    logic eof;
  } s2_t;

  typedef struct packed {
    logic             emit;
    logic             inter;
    logic             eol;
    logic             eof;
    logic [PIX_W-1:0] lo_max;
    logic [PIX_W-1:0] mid_med;
    logic [PIX_W-1:0] hi_min;
  } s3_t;

  logic [COLS_W-1:0] frame_cols_r;
  logic [ROWS_W-1:0] frame_rows_r;
  logic [CEW-1:0]    cols_raw;
  logic [CEW-1:0]    cols_lim;
  logic [REW-1:0]    rows_raw;
  logic [REW-1:0]    rows_lim;
  logic [CNTW-1:0]   cols;
  logic [RNTW-1:0]   rows;

  logic [CB-1:0]     in_col_r, in_col_nxt;
  logic [RB-1:0]     in_row_r, in_row_nxt;
  logic [CB-1:0]     out_col_r, out_col_nxt;
  logic [RB-1:0]     out_row_r, out_row_nxt;
  logic [LW-1:0]     lag_r, lag_nxt;
  logic [CNTW-1:0]   ic_inc, oc_inc;
  logic [RNTW-1:0]   ir_inc, or_inc;

  logic              acc, pix, emit;
  logic              inter, eol, eof;

  s1_t               s1_r, s1_nxt;
  s2_t               s2_r, s2_nxt;
  s3_t               s3_r, s3_nxt;

  logic [LINE_W-1:0] ram_q;
  logic [LINE_W-1:0] tm;
  logic [LINE_W-1:0] ram_wdata;
  logic              ram_we;
  logic              ram_re;
  logic              fwd_r, fwd_nxt;
  logic [LINE_W-1:0] fwd_data_r;

  mf_col_t           new_col;
  mf_col_t           cell_in [WIN_N];
  mf_col_t           cell_q  [WIN_N];
  logic              shift_en;
  logic [PIX_W-1:0]  med;

  mf_out_t           fifo_r [FIFO_DEPTH];
  logic [FPW-1:0]    wptr_r, rptr_r;
  logic [FCW-1:0]    cnt_r, cnt_nxt;
  logic [FCW-1:0]    cred_r, cred_nxt;
  logic              fire;
  mf_out_t           head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cols_r <= COLS_RESET;
      frame_rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      case (mf_cfg_idx_t'(cfg_index))
        CFG_FRAME_COLS: frame_cols_r <= cfg_wdata[COLS_W-1:0];
        CFG_FRAME_ROWS: frame_rows_r <= cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry in use: zero counts as one, and the size is capped at the store limits.
  assign cols_raw = CEW'(frame_cols_r);
  assign rows_raw = REW'(frame_rows_r);

  always_comb begin
    if (cols_raw == '0) begin
      cols_lim = CEW'(1);
    end else if (cols_raw > CEW'(MAX_COLS)) begin
      cols_lim = CEW'(MAX_COLS);
    end else begin
      cols_lim = cols_raw;
    end
    if (rows_raw == '0) begin
      rows_lim = REW'(1);
    end else if (rows_raw > REW'(MAX_ROWS)) begin
      rows_lim = REW'(MAX_ROWS);
    end else begin
      rows_lim = rows_raw;
    end
  end

  assign cols = CNTW'(cols_lim);
  assign rows = RNTW'(rows_lim);

  // Accept decision, lag and the position of the next input and result.
  assign acc    = in_ch.valid && in_ch.ready;
  assign pix    = !in_ch.drain;
  assign ic_inc = CNTW'(in_col_r) + CNTW'(1);
  assign ir_inc = RNTW'(in_row_r) + RNTW'(1);
  assign oc_inc = CNTW'(out_col_r) + CNTW'(1);
  assign or_inc = RNTW'(out_row_r) + RNTW'(1);

  always_comb begin
    if (pix) begin
      emit = acc && (lag_r > LW'(cols));
    end else begin
      emit = acc && (in_col_r == '0) && (in_row_r == '0) && (lag_r != '0);
    end

    inter = (out_row_r != '0) && (or_inc < rows) && (out_col_r != '0) && (oc_inc < cols);
    eol   = (oc_inc >= cols);
    eof   = eol && (or_inc >= rows);

    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (acc && pix) begin
      if (ic_inc >= cols) begin
        in_col_nxt = '0;
        in_row_nxt = (ir_inc >= rows) ? '0 : RB'(ir_inc);
      end else begin
        in_col_nxt = CB'(ic_inc);
      end
    end

    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      if (eol) begin
        out_col_nxt = '0;
        out_row_nxt = (or_inc >= rows) ? '0 : RB'(or_inc);
      end else begin
        out_col_nxt = CB'(oc_inc);
      end
    end

    lag_nxt = lag_r;
    if (acc && pix && !emit) begin
      lag_nxt = lag_r + LW'(1);
    end else if (acc && !pix && emit) begin
      lag_nxt = lag_r - LW'(1);
    end

    s1_nxt.vld   = acc;
    s1_nxt.pix   = pix;
    s1_nxt.emit  = emit;
    s1_nxt.inter = inter;
    s1_nxt.eol   = eol;
    s1_nxt.eof   = eof;
    s1_nxt.addr  = in_col_r;
    s1_nxt.px    = in_ch.pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lag_r     <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lag_r     <= lag_nxt;
    end
  end

  // Line stores: both lines share one entry, read at accept and rewritten in the cycle after.
  assign ram_re = acc && pix;

  mf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_r.addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_col_r),
    .rdata (ram_q)
  );

  // Stage 1: forward a write that landed on the same edge as the read, then
  // sort the new column and shift it into the window.
  always_comb begin
    tm        = fwd_r ? fwd_data_r : ram_q;
    ram_we    = s1_r.vld && s1_r.pix;
    ram_wdata = {tm[PIX_W-1:0], s1_r.px};
    new_col   = sort3(tm[LINE_W-1:PIX_W], tm[PIX_W-1:0], s1_r.px);
    shift_en  = s1_r.vld && s1_r.pix;
    fwd_nxt   = ram_we && ram_re && (s1_r.addr == in_col_r);

    s2_nxt.emit  = s1_r.emit;
    s2_nxt.inter = s1_r.inter;
    s2_nxt.eol   = s1_r.eol;
    s2_nxt.eof   = s1_r.eof;
  end

  // Window: a chain of column cells, newest column first.
  assign cell_in[0] = new_col;

  for (genvar k = 0; k < WIN_N; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign cell_in[k] = cell_q[k-1];
    end
    mf_col_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .col_in   (cell_in[k]),
      .col_q    (cell_q[k])
    );
  end

  // Stage 2: largest low, middle of mids and smallest high across the columns.
  always_comb begin
    s3_nxt.emit    = s2_r.emit;
    s3_nxt.inter   = s2_r.inter;
    s3_nxt.eol     = s2_r.eol;
    s3_nxt.eof     = s2_r.eof;
    s3_nxt.lo_max  = max3(cell_q[0].lo, cell_q[1].lo, cell_q[2].lo);
    s3_nxt.mid_med = med3(cell_q[0].mid, cell_q[1].mid, cell_q[2].mid);
    s3_nxt.hi_min  = min3(cell_q[0].hi, cell_q[1].hi, cell_q[2].hi);
  end

  // Stage 3: the median of the nine is the median of those three.
  assign med = med3(s3_r.lo_max, s3_r.mid_med, s3_r.hi_min);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld  <= 1'b0;
      s1_r.emit <= 1'b0;
      s2_r.emit <= 1'b0;
      s3_r.emit <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      fwd_r <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= ram_wdata;
  end

  // Output queue with a credit count of results owed, in flight or queued.
  assign fire     = out_ch.valid && out_ch.ready;
  assign cnt_nxt  = cnt_r + FCW'(s3_r.emit) - FCW'(fire);
  assign cred_nxt = cred_r + FCW'(emit) - FCW'(fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
      cred_r <= '0;
    end else begin
      if (s3_r.emit) begin
        wptr_r <= wptr_r + FPW'(1);
      end
      if (fire) begin
        rptr_r <= rptr_r + FPW'(1);
      end
      cnt_r  <= cnt_nxt;
      cred_r <= cred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_r.emit) begin
      fifo_r[wptr_r].filtered     <= s3_r.inter ? med : '0;
      fifo_r[wptr_r].end_of_line  <= s3_r.eol;
      fifo_r[wptr_r].end_of_frame <= s3_r.eof;
    end
  end

  assign head                = fifo_r[rptr_r];
  assign in_ch.ready         = (cred_r < FCW'(FIFO_DEPTH));
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.filtered     = head.filtered;
  assign out_ch.end_of_line  = head.end_of_line;
  assign out_ch.end_of_frame = head.end_of_frame;

  // Every owed result sits in exactly one pipeline stage or in the queue.
  a_credit_match: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r == cnt_r + FCW'(s1_r.emit) + FCW'(s2_r.emit) + FCW'(s3_r.emit))
    else $error("credit count disagrees with results in flight");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= FCW'(FIFO_DEPTH))
    else $error("more results owed than the queue can hold");

  // A forwarded line entry only ever follows a pixel whose write is under way.
  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (s1_r.vld && s1_r.pix && $past(ram_we)))
    else $error("line store forward without a matching write");

  // Drains never move the window columns.
  a_drain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r.vld && !s1_r.pix) |=> $stable(cell_q[0]))
    else $error("window moved on a drain item");

endmodule

`default_nettype wire
